>>> hw/rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants of the tone melody sequencer
// Table geometry, command and register codes, divider handshake structs.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	localparam int CLK_W   = 24;
	localparam int FREQ_W  = 16;
	localparam int TICKS_W = 16;
	localparam int DIV_W   = 16;
	localparam int POS_W   = 9;
	localparam int IDX_W   = 8;
	localparam int CFG_A_W = 3;
	localparam int CFG_D_W = 24;

	localparam logic [DIV_W-1:0] DIV_MAX = '1;
	localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(2);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_TIMER_CLOCK = 3'd0,
		CFG_MIN_FREQ    = 3'd1,
		CFG_MAX_FREQ    = 3'd2,
		CFG_ENTRY_COUNT = 3'd3,
		CFG_LOOP_START  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [TICKS_W-1:0] ticks;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [CLK_W-1:0]  dividend;
		logic [FREQ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CLK_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/tms_ifs.sv
// ----------------------------------------------------------------------------
// tms_ifs: channel interfaces of the tone melody sequencer
// Item, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tms_item_if
	import tms_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [IDX_W-1:0]  entry_index;
	logic [FREQ_W-1:0] note_freq;
	logic [TICKS_W-1:0] note_ticks;

	modport source (output valid, cmd, entry_index, note_freq, note_ticks, input ready);
	modport sink   (input valid, cmd, entry_index, note_freq, note_ticks, output ready);
endinterface

interface tms_result_if
	import tms_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             speaker_gate;
	logic [DIV_W-1:0] divisor;
	logic             divisor_load;
	logic [POS_W-1:0] position;

	modport source (output valid, speaker_gate, divisor, divisor_load, position, input ready);
	modport sink   (input valid, speaker_gate, divisor, divisor_load, position, output ready);
endinterface

interface tms_cfg_if
	import tms_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CFG_A_W-1:0] index;
	logic [CFG_D_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tms_table_ram.sv
// ----------------------------------------------------------------------------
// tms_table_ram: melody table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tms_table_ram
	import tms_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tms_divider.sv
// ----------------------------------------------------------------------------
// tms_divider: serial restoring divider
// One quotient bit per cycle; quotient valid with the done pulse.
// ----------------------------------------------------------------------------
module tms_divider
	import tms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(CLK_W);

	logic [FREQ_W-1:0] rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [FREQ_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [FREQ_W:0]   rem_sh;
	logic              ge;
	logic [FREQ_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[CLK_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hw/rtl/tone_melody_sequencer.sv
// ----------------------------------------------------------------------------
// tone_melody_sequencer: melody player for a square-wave tone timer
// Load beats fill the melody table; tick beats step playback and report
// gate, divisor and position. One result beat per input beat.
// A load or a tick that fetches nothing goes straight to the output state;
// a fetched rest or clamped note passes the fetch state first; a note to
// divide also waits for the serial divider. One item in flight at a time:
// a new beat waits until the last result is taken into the output register.
// Reset: registers to defaults, gate on, divisor 0, position 0; table
// contents are undefined until loaded. No clearing pass.
// ----------------------------------------------------------------------------
module tone_melody_sequencer
	import tms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tms_item_if.sink     item_in,
	tms_result_if.source result_out,
	tms_cfg_if.sink      cfg
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	logic [CLK_W-1:0]   timer_clock_q;
	logic [FREQ_W-1:0]  min_freq_q;
	logic [CLK_W-1:0]   max_freq_q;
	logic [POS_W-1:0]   entry_count_q;
	logic [IDX_W-1:0]   loop_start_q;

	logic [POS_W-1:0]   play_q;
	logic [TICKS_W-1:0] wait_q;
	logic               gate_q;
	logic [DIV_W-1:0]   tone_div_q;
	logic               loaded_q;

	logic               out_valid_q;
	logic               out_gate_q;
	logic [DIV_W-1:0]   out_div_q;
	logic               out_loaded_q;
	logic [POS_W-1:0]   out_pos_q;

	logic               accept;
	logic               is_tick;
	logic [POS_W-1:0]   pos;
	logic               ram_we;
	entry_t             ram_wdata;
	entry_t             ram_rdata;
	logic               ram_re;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic               out_free;
	logic [DIV_W-1:0]   div_sat;

	assign item_in.ready = (state_q == ST_IDLE);
	assign accept        = item_in.valid && item_in.ready;
	assign is_tick       = (item_in.cmd == CMD_TICK);
	assign cfg.ready     = 1'b1;

	assign pos = (play_q == entry_count_q) ? POS_W'(loop_start_q) : play_q;

	assign ram_we          = accept && !is_tick
		&& (32'(item_in.entry_index) < TABLE_DEPTH);
	assign ram_wdata.freq  = item_in.note_freq;
	assign ram_wdata.ticks = item_in.note_ticks;
	assign ram_re          = accept && is_tick && (wait_q == '0);

	tms_table_ram u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(item_in.entry_index)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(pos)),
		.rdata (ram_rdata)
	);

	assign div_req.start    = (state_q == ST_FETCH) && (ram_rdata.freq != '0)
		&& (ram_rdata.freq > min_freq_q)
		&& !(CLK_W'(ram_rdata.freq) > max_freq_q);
	assign div_req.dividend = timer_clock_q;
	assign div_req.divisor  = ram_rdata.freq;

	tms_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_sat  = (div_rsp.quotient[CLK_W-1:DIV_W] != '0) ? DIV_MAX
		: div_rsp.quotient[DIV_W-1:0];
	assign out_free = !out_valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_clock_q <= CLK_W'(1193182);
			min_freq_q    <= FREQ_W'(18);
			max_freq_q    <= CLK_W'(596591);
			entry_count_q <= POS_W'(1);
			loop_start_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_TIMER_CLOCK: timer_clock_q <= cfg.data;
				CFG_MIN_FREQ:    min_freq_q    <= cfg.data[FREQ_W-1:0];
				CFG_MAX_FREQ:    max_freq_q    <= cfg.data;
				CFG_ENTRY_COUNT: entry_count_q <= cfg.data[POS_W-1:0];
				CFG_LOOP_START:  loop_start_q  <= cfg.data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			play_q     <= '0;
			wait_q     <= '0;
			gate_q     <= 1'b1;
			tone_div_q <= '0;
			loaded_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						loaded_q <= 1'b0;
						if (!is_tick) begin
							state_q <= ST_OUT;
						end else begin
							play_q <= pos;
							if (wait_q == '0) begin
								state_q <= ST_FETCH;
							end else begin
								wait_q  <= wait_q - TICKS_W'(1);
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_FETCH: begin
					play_q <= play_q + POS_W'(1);
					wait_q <= (ram_rdata.ticks == '0) ? '0
						: ram_rdata.ticks - TICKS_W'(1);
					if (ram_rdata.freq == '0) begin
						gate_q  <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						gate_q   <= 1'b1;
						loaded_q <= 1'b1;
						if (ram_rdata.freq <= min_freq_q) begin
							tone_div_q <= DIV_MAX;
							state_q    <= ST_OUT;
						end else if (CLK_W'(ram_rdata.freq) > max_freq_q) begin
							tone_div_q <= DIV_MIN;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						tone_div_q <= div_sat;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_gate_q   <= gate_q;
			out_div_q    <= tone_div_q;
			out_loaded_q <= loaded_q;
			out_pos_q    <= play_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.speaker_gate = out_gate_q;
	assign result_out.divisor      = out_div_q;
	assign result_out.divisor_load = out_loaded_q;
	assign result_out.position     = out_pos_q;

	a_div_start_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> state_q == ST_FETCH)
		else $error("divider started outside fetch");

	a_div_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(div_rsp.done && state_q == ST_DIV) |=> state_q == ST_OUT)
		else $error("divider result not taken");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !item_in.ready)
		else $error("beat accepted while dividing");

	a_load_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_loaded_q) |-> out_gate_q)
		else $error("divisor load with gate off");

endmodule
